/* hdl/cda_pkg.sv */
// Shared types, constants, microcode program and calendar helpers for the date adder.
`default_nettype none

package cda_pkg;

    // Default widths handed to the top level.
    localparam int CDA_YEAR_BITS   = 16;
    localparam int CDA_AMOUNT_BITS = 16;

    // Calendar constants.
    localparam int unsigned CDA_DAYS_PER_CYCLE = 146097;
    localparam int unsigned CDA_YEARS_PER_CYCLE = 400;
    localparam logic [4:0] CDA_LEAP_DIV   = 5'd25;
    localparam logic [4:0] CDA_MONTH_DIV  = 5'd12;
    localparam logic [3:0] CDA_LAST_MONTH = 4'd12;
    localparam logic [4:0] CDA_MAX_DAY    = 5'd31;
    localparam logic [4:0] CDA_LEAP_FEB   = 5'd29;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_SET        = 2'd0,
        OP_ADD_DAYS   = 2'd1,
        OP_ADD_MONTHS = 2'd2,
        OP_ADD_YEARS  = 2'd3
    } t_op;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_DAY   = 2'd2,
        ST_YEAR_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [15:0] amount;
        logic [15:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        t_status     status;
    } t_out_item;

    // Datapath operations selected by one control word.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_DIV_SETY,
        DP_DIV_MON,
        DP_DIV_YEAR,
        DP_DIV_STEP,
        DP_SET_APPLY,
        DP_CYC400,
        DP_WALK,
        DP_MON_APPLY,
        DP_YEAR_APPLY,
        DP_CLAMP
    } t_dp_op;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DIV_RUN,
        JC_CYC_GO,
        JC_WALK_GO
    } t_cond;

    typedef logic [3:0] t_uaddr;

    typedef struct packed {
        t_dp_op dp;
        t_cond  cond;
        t_uaddr target;
        logic   done;
    } t_cword;

    // Status the datapath reports to the sequencer for its jumps.
    typedef struct packed {
        logic div_run;
        logic cyc_go;
        logic walk_go;
    } t_dp_flags;

    // Microcode addresses.
    localparam t_uaddr UA_SET        = 4'd0;
    localparam t_uaddr UA_SET_STEP   = 4'd1;
    localparam t_uaddr UA_SET_APPLY  = 4'd2;
    localparam t_uaddr UA_SET_DONE   = 4'd3;
    localparam t_uaddr UA_DAYS       = 4'd4;
    localparam t_uaddr UA_DAYS_WALK  = 4'd5;
    localparam t_uaddr UA_DAYS_DONE  = 4'd6;
    localparam t_uaddr UA_MONTHS     = 4'd7;
    localparam t_uaddr UA_MON_STEP   = 4'd8;
    localparam t_uaddr UA_MON_APPLY  = 4'd9;
    localparam t_uaddr UA_FIX_YEAR   = 4'd10;
    localparam t_uaddr UA_FIX_STEP   = 4'd11;
    localparam t_uaddr UA_FIX_CLAMP  = 4'd12;
    localparam t_uaddr UA_FIX_DONE   = 4'd13;
    localparam t_uaddr UA_YEARS      = 4'd14;

    function automatic t_cword cda_cw(t_dp_op dp, t_cond cond, t_uaddr target,
                                      logic done);
        t_cword w;
        w.dp     = dp;
        w.cond   = cond;
        w.target = target;
        w.done   = done;
        return w;
    endfunction

    // The control program, one word per step.
    function automatic t_cword cda_ucode(t_uaddr a);
        t_cword w;
        unique case (a)
            UA_SET:       w = cda_cw(DP_DIV_SETY,   JC_NEXT,    UA_SET,       1'b0);
            UA_SET_STEP:  w = cda_cw(DP_DIV_STEP,   JC_DIV_RUN, UA_SET_STEP,  1'b0);
            UA_SET_APPLY: w = cda_cw(DP_SET_APPLY,  JC_NEXT,    UA_SET,       1'b0);
            UA_SET_DONE:  w = cda_cw(DP_NOP,        JC_NEXT,    UA_SET,       1'b1);
            UA_DAYS:      w = cda_cw(DP_CYC400,     JC_CYC_GO,  UA_DAYS,      1'b0);
            UA_DAYS_WALK: w = cda_cw(DP_WALK,       JC_WALK_GO, UA_DAYS_WALK, 1'b0);
            UA_DAYS_DONE: w = cda_cw(DP_NOP,        JC_NEXT,    UA_SET,       1'b1);
            UA_MONTHS:    w = cda_cw(DP_DIV_MON,    JC_NEXT,    UA_SET,       1'b0);
            UA_MON_STEP:  w = cda_cw(DP_DIV_STEP,   JC_DIV_RUN, UA_MON_STEP,  1'b0);
            UA_MON_APPLY: w = cda_cw(DP_MON_APPLY,  JC_NEXT,    UA_SET,       1'b0);
            UA_FIX_YEAR:  w = cda_cw(DP_DIV_YEAR,   JC_NEXT,    UA_SET,       1'b0);
            UA_FIX_STEP:  w = cda_cw(DP_DIV_STEP,   JC_DIV_RUN, UA_FIX_STEP,  1'b0);
            UA_FIX_CLAMP: w = cda_cw(DP_CLAMP,      JC_NEXT,    UA_SET,       1'b0);
            UA_FIX_DONE:  w = cda_cw(DP_NOP,        JC_NEXT,    UA_SET,       1'b1);
            UA_YEARS:     w = cda_cw(DP_YEAR_APPLY, JC_ALWAYS,  UA_FIX_YEAR,  1'b0);
            default:      w = cda_cw(DP_NOP,        JC_NEXT,    UA_SET,       1'b1);
        endcase
        return w;
    endfunction

    // First step of each operation.
    function automatic t_uaddr cda_entry(t_op op);
        t_uaddr a;
        unique case (op)
            OP_SET:        a = UA_SET;
            OP_ADD_DAYS:   a = UA_DAYS;
            OP_ADD_MONTHS: a = UA_MONTHS;
            OP_ADD_YEARS:  a = UA_YEARS;
            default:       a = UA_SET;
        endcase
        return a;
    endfunction

    // Leap test from the low year bits and the year modulo 25.
    // A year divisible by 100 is one divisible by 4 and by 25.
    function automatic logic cda_is_leap(logic [3:0] y_low, logic [4:0] y_mod25);
        return (y_low[1:0] == 2'd0) && ((y_mod25 != 5'd0) || (y_low == 4'd0));
    endfunction

    // Month length; months outside 1 to 12 read as 31.
    function automatic logic [4:0] cda_month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:    len = leap ? CDA_LEAP_FEB : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = CDA_MAX_DAY;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

/* hdl/cda_moddiv.sv */
// Two-step division by a small constant (25 or 12) by reciprocal multiplication.
`default_nettype none

module cda_moddiv
    import cda_pkg::*;
#(
    parameter int XW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_by25,
    input  wire logic [XW-1:0] i_dividend,
    input  wire logic          i_step,
    output logic               o_run,
    output logic [XW-1:0]      o_quot,
    output logic [4:0]         o_rem
);

    // Reciprocal constants. Division by 12 is a shift by two and a division by 3.
    // Both shifts leave enough fraction bits that the quotient is exact for every
    // dividend below 2^XW.
    localparam int MW  = XW + 1;
    localparam int PW  = 2 * XW + 1;
    localparam int S25 = XW + 5;
    localparam int S3  = XW - 1;
    localparam longint unsigned D25_L = 64'(CDA_LEAP_DIV);
    localparam longint unsigned M25_L = ((64'd1 << S25) + D25_L - 64'd1) / D25_L;
    localparam longint unsigned M3_L  = ((64'd1 << S3) + 64'd2) / 64'd3;
    localparam logic [MW-1:0] M25 = MW'(M25_L);
    localparam logic [MW-1:0] M3  = MW'(M3_L);

    logic [1:0]    r_cnt, n_cnt;
    logic [XW-1:0] r_dvd, n_dvd;
    logic [XW-1:0] r_quot, n_quot;
    logic [4:0]    r_rem, n_rem;
    logic          r_by25, n_by25;
    logic [XW-1:0] opnd;
    logic [MW-1:0] recip;
    logic [PW-1:0] prod;
    logic [XW-1:0] quot_mul;
    logic [XW-1:0] back;

    // First step forms the quotient, second step multiplies back for the remainder.
    always_comb begin
        opnd     = r_by25 ? r_dvd : (r_dvd >> 2);
        recip    = r_by25 ? M25 : M3;
        prod     = PW'(opnd) * PW'(recip);
        quot_mul = r_by25 ? XW'(prod >> S25) : XW'(prod >> S3);
        back     = r_by25 ? (r_quot * XW'(CDA_LEAP_DIV)) : (r_quot * XW'(CDA_MONTH_DIV));
        n_cnt    = r_cnt;
        n_dvd    = r_dvd;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_by25   = r_by25;
        if (i_start) begin
            n_cnt  = 2'd2;
            n_dvd  = i_dividend;
            n_by25 = i_by25;
        end else if (i_step && (r_cnt == 2'd2)) begin
            n_cnt  = 2'd1;
            n_quot = quot_mul;
        end else if (i_step && (r_cnt == 2'd1)) begin
            n_cnt = 2'd0;
            n_rem = 5'(r_dvd - back);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_by25 <= n_by25;
    end

    assign o_run  = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* hdl/cda_dpath.sv */
// Date registers and the datapath that the microcode steps drive.
`default_nettype none

module cda_dpath
    import cda_pkg::*;
#(
    parameter int YEAR_BITS   = CDA_YEAR_BITS,
    parameter int AMOUNT_BITS = CDA_AMOUNT_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_in_item  i_item,
    input  wire t_dp_op    i_dp_op,
    output t_dp_flags      o_flags,
    output t_out_item      o_result
);

    localparam int XW0 = (YEAR_BITS > AMOUNT_BITS + 1) ? YEAR_BITS : AMOUNT_BITS + 1;
    localparam int XW  = (XW0 > 18) ? XW0 : 18;
    localparam longint unsigned YMAX_L = (64'd1 << YEAR_BITS) - 64'd1;
    localparam logic [4:0] YMAX_MOD25 = 5'(YMAX_L % 64'd25);
    localparam logic [YEAR_BITS-1:0] YMAX = {YEAR_BITS{1'b1}};
    localparam logic [XW-1:0] CYC_DAYS = XW'(CDA_DAYS_PER_CYCLE);
    localparam logic [XW-1:0] CYC_YEARS = XW'(CDA_YEARS_PER_CYCLE);

    logic [YEAR_BITS-1:0]   r_year, n_year;
    logic [3:0]             r_month, n_month;
    logic [4:0]             r_day, n_day;
    t_status                r_status, n_status;
    logic [4:0]             r_y25, n_y25;
    logic [AMOUNT_BITS-1:0] r_n, n_n;
    logic [YEAR_BITS-1:0]   r_set_year, n_set_year;
    logic [3:0]             r_set_month, n_set_month;
    logic [4:0]             r_set_day, n_set_day;

    logic                   div_start, div_by25, div_step, div_run;
    logic [XW-1:0]          div_dividend, div_quot;
    logic [4:0]             div_rem;

    logic                   leap_cur, leap_new, do_sat;
    logic [4:0]             len_cur, len_new, room_day;
    logic [YEAR_BITS-1:0]   year_room;
    logic [XW-1:0]          n_x, room_x;
    logic                   n_ge_cyc, n_gt_day, year_top, month_end;

    cda_moddiv #(
        .XW(XW)
    ) u_moddiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_by25     (div_by25),
        .i_dividend (div_dividend),
        .i_step     (div_step),
        .o_run      (div_run),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Conditions on the current date and the days still to add.
    always_comb begin
        leap_cur  = cda_is_leap(r_year[3:0], r_y25);
        len_cur   = cda_month_len(r_month, leap_cur);
        room_day  = len_cur - r_day;
        year_room = YMAX - r_year;
        n_x       = XW'(r_n);
        room_x    = XW'(year_room);
        n_ge_cyc  = (n_x >= CYC_DAYS);
        n_gt_day  = (r_n > AMOUNT_BITS'(room_day));
        year_top  = (r_year == YMAX);
        month_end = (r_month >= CDA_LAST_MONTH);
    end

    assign o_flags.div_run = div_run;
    assign o_flags.cyc_go  = n_ge_cyc && (room_x >= CYC_YEARS);
    assign o_flags.walk_go = (r_status != ST_YEAR_SAT) && n_gt_day && !(month_end && year_top);

    // Next values of the date registers for the selected operation.
    always_comb begin
        n_year       = r_year;
        n_month      = r_month;
        n_day        = r_day;
        n_status     = r_status;
        n_y25        = r_y25;
        n_n          = r_n;
        n_set_year   = r_set_year;
        n_set_month  = r_set_month;
        n_set_day    = r_set_day;
        div_start    = 1'b0;
        div_by25     = 1'b0;
        div_step     = 1'b0;
        div_dividend = '0;
        do_sat       = 1'b0;
        leap_new     = cda_is_leap(r_set_year[3:0], div_rem);
        len_new      = cda_month_len(r_set_month, leap_new);
        if (i_load) begin
            n_set_year  = YEAR_BITS'(i_item.set_year);
            n_set_month = i_item.set_month;
            n_set_day   = i_item.set_day;
            n_n         = AMOUNT_BITS'(i_item.amount);
            n_status    = ST_OK;
        end else begin
            unique case (i_dp_op)
                DP_NOP: begin
                end
                DP_DIV_SETY: begin
                    div_start    = 1'b1;
                    div_by25     = 1'b1;
                    div_dividend = XW'(r_set_year);
                end
                DP_DIV_MON: begin
                    div_start    = 1'b1;
                    div_dividend = XW'(r_month) - XW'(1) + n_x;
                end
                DP_DIV_YEAR: begin
                    div_start    = 1'b1;
                    div_by25     = 1'b1;
                    div_dividend = XW'(r_year);
                end
                DP_DIV_STEP: begin
                    div_step = 1'b1;
                end
                DP_SET_APPLY: begin
                    // Month is checked before day.
                    if ((r_set_month == 4'd0) || (r_set_month > CDA_LAST_MONTH)) begin
                        n_status = ST_BAD_MONTH;
                    end else if ((r_set_day == 5'd0) || (r_set_day > len_new)) begin
                        n_status = ST_BAD_DAY;
                    end else begin
                        n_year  = r_set_year;
                        n_month = r_set_month;
                        n_day   = r_set_day;
                        n_y25   = div_rem;
                    end
                end
                DP_CYC400: begin
                    // A whole 400-year cycle keeps month, day and year mod 25.
                    if (n_ge_cyc) begin
                        if (room_x < CYC_YEARS) begin
                            do_sat = 1'b1;
                        end else begin
                            n_year = r_year + YEAR_BITS'(CDA_YEARS_PER_CYCLE);
                            n_n    = r_n - AMOUNT_BITS'(CDA_DAYS_PER_CYCLE);
                        end
                    end
                end
                DP_WALK: begin
                    // Finish inside this month, or move to the first of the next.
                    if (r_status != ST_YEAR_SAT) begin
                        if (!n_gt_day) begin
                            n_day = r_day + r_n[4:0];
                            n_n   = '0;
                        end else begin
                            n_n   = r_n - AMOUNT_BITS'(room_day) - AMOUNT_BITS'(1);
                            n_day = 5'd1;
                            if (month_end) begin
                                if (year_top) begin
                                    do_sat = 1'b1;
                                end else begin
                                    n_year  = r_year + YEAR_BITS'(1);
                                    n_month = 4'd1;
                                    n_y25   = (r_y25 == CDA_LEAP_DIV - 5'd1) ? 5'd0
                                                                              : r_y25 + 5'd1;
                                end
                            end else begin
                                n_month = r_month + 4'd1;
                            end
                        end
                    end
                end
                DP_MON_APPLY: begin
                    if (div_quot > room_x) begin
                        do_sat = 1'b1;
                    end else begin
                        n_year  = r_year + YEAR_BITS'(div_quot);
                        n_month = div_rem[3:0] + 4'd1;
                    end
                end
                DP_YEAR_APPLY: begin
                    if (n_x > room_x) begin
                        do_sat = 1'b1;
                    end else begin
                        n_year = r_year + YEAR_BITS'(r_n);
                    end
                end
                DP_CLAMP: begin
                    n_y25 = div_rem;
                    if (r_day > cda_month_len(r_month, cda_is_leap(r_year[3:0], div_rem))) begin
                        n_day = cda_month_len(r_month, cda_is_leap(r_year[3:0], div_rem));
                    end
                end
                default: begin
                end
            endcase
        end
        // Year overflow pins the date to the last representable day.
        if (do_sat) begin
            n_year   = YMAX;
            n_month  = CDA_LAST_MONTH;
            n_day    = CDA_MAX_DAY;
            n_y25    = YMAX_MOD25;
            n_status = ST_YEAR_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= '0;
            r_month  <= 4'd1;
            r_day    <= 5'd1;
            r_y25    <= 5'd0;
            r_status <= ST_OK;
        end else begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_y25    <= n_y25;
            r_status <= n_status;
        end
        r_n         <= n_n;
        r_set_year  <= n_set_year;
        r_set_month <= n_set_month;
        r_set_day   <= n_set_day;
    end

    assign o_result.cur_year  = 16'(r_year);
    assign o_result.cur_month = r_month;
    assign o_result.cur_day   = r_day;
    assign o_result.status    = r_status;

endmodule

`default_nettype wire

/* hdl/cda_useq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module cda_useq
    import cda_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_start,
    input  wire t_op       i_op,
    input  wire t_dp_flags i_flags,
    input  wire logic      i_out_free,
    output logic           o_busy,
    output t_dp_op         o_dp_op,
    output logic           o_emit
);

    logic   r_busy, n_busy;
    t_uaddr r_pc, n_pc;
    t_cword cw;
    logic   take_jump;

    assign cw = cda_ucode(r_pc);

    // Jump condition of the current control word.
    always_comb begin
        unique case (cw.cond)
            JC_NEXT:    take_jump = 1'b0;
            JC_ALWAYS:  take_jump = 1'b1;
            JC_DIV_RUN: take_jump = i_flags.div_run;
            JC_CYC_GO:  take_jump = i_flags.cyc_go;
            JC_WALK_GO: take_jump = i_flags.walk_go;
            default:    take_jump = 1'b0;
        endcase
    end

    // Next step.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = cda_entry(i_op);
            end
        end else if (cw.done) begin
            if (i_out_free) begin
                n_busy = 1'b0;
            end
        end else begin
            n_pc = take_jump ? cw.target : r_pc + 4'd1;
        end
    end

    // Outputs of the current step.
    always_comb begin
        o_busy  = r_busy;
        o_dp_op = r_busy ? cw.dp : DP_NOP;
        o_emit  = r_busy && cw.done && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UA_SET;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

`default_nettype wire

/* hdl/calendar_date_adder.sv */
// Top level of the Gregorian date adder: handshakes, sequencer, datapath and result register.
//
// The block holds one date and applies one operation per input transfer: set the date,
// add days, add months or add years; each transfer gives one result with the new date
// and a status. Items are worked one at a time, and a finished result waits in an output
// register while the next item is accepted. A microcoded sequencer runs each operation;
// a two-step remainder unit (a reciprocal multiplication, then a multiply back and a
// subtract) finds year mod 25 and month carries.
// Add days first takes whole 400-year blocks (146097 days) off the amount, then walks
// across month boundaries, one per cycle, until the rest fits in the current month or
// the year saturates. A stalled earlier result holds the new one back until it leaves.
// No clearing pass follows reset: the date is 1 January of year 0 at once.
`default_nettype none

module calendar_date_adder
    import cda_pkg::*;
#(
    parameter int YEAR_BITS   = CDA_YEAR_BITS,
    parameter int AMOUNT_BITS = CDA_AMOUNT_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    logic      busy, emit, in_xfer, out_free;
    t_dp_op    dp_op;
    t_dp_flags flags;
    t_out_item result;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign in_xfer    = i_in_valid && !busy;
    assign o_in_stall = busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    cda_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_op       (i_in_data.op),
        .i_flags    (flags),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_dp_op    (dp_op),
        .o_emit     (emit)
    );

    cda_dpath #(
        .YEAR_BITS   (YEAR_BITS),
        .AMOUNT_BITS (AMOUNT_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_xfer),
        .i_item   (i_in_data),
        .i_dp_op  (dp_op),
        .o_flags  (flags),
        .o_result (result)
    );

    // Result register; it holds until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (emit) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* hdl/cda_checker.sv */
// Port-level assertions for the date adder and the bind that attaches them.
`default_nettype none

module cda_checker
    import cda_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // An accepted transfer is followed by a stalled input side.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // Every reported date has a real month and a nonzero day.
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.cur_month >= 4'd1) && (o_out_data.cur_month <= 4'd12)
                         && (o_out_data.cur_day != 5'd0)))
        else $error("result date out of range");

    // Year saturation always reports the last day of the year.
    a_sat_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_YEAR_SAT)) |->
            ((o_out_data.cur_month == CDA_LAST_MONTH) && (o_out_data.cur_day == CDA_MAX_DAY)))
        else $error("saturated result is not the last day of the year");

endmodule

bind calendar_date_adder cda_checker u_cda_checker (.*);

`default_nettype wire
